// ===== src/lkv_pkg.sv =====
// Shared constants, payload types and state codes for the LRU key-value cache.
package lkv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CAP_W      = 5;
    localparam int CAP_RESET  = 16;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
        logic [KEY_BITS-1:0]   evicted_key;
    } rsp_t;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    typedef struct packed {
        logic look;
        logic shift;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPDATE
    } state_t;

endpackage

// ===== src/lkv_cell.sv =====
// One recency slot of the cache: holds an entry, matches keys, takes its neighbor on shift.
module lkv_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lkv_pkg::cell_ctl_t                  ctl,
    input  logic [lkv_pkg::KEY_BITS-1:0]        look_key,
    input  lkv_pkg::entry_t                     neighbor,
    input  logic                                next_valid,
    output lkv_pkg::entry_t                     entry,
    output logic                                match,
    output logic [lkv_pkg::VALUE_BITS-1:0]      hit_value,
    output logic [lkv_pkg::KEY_BITS-1:0]        tail_key
);

    logic                           valid_reg;
    logic [lkv_pkg::KEY_BITS-1:0]   key_reg;
    logic [lkv_pkg::VALUE_BITS-1:0] value_reg;
    logic                           match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctl.shift)
            begin
                valid_reg <= neighbor.valid;
            end
            if (ctl.look)
            begin
                match_reg <= valid_reg && (key_reg == look_key);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            key_reg   <= neighbor.key;
            value_reg <= neighbor.value;
        end
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;
    assign match       = match_reg;

    // valid slots form a prefix, so the last valid one is the least recent
    assign hit_value = match_reg ? value_reg : '0;
    assign tail_key  = (valid_reg && !next_valid) ? key_reg : '0;

endmodule

// ===== src/lkv_ctrl.sv =====
// Sequencer of the cache: request capture, shift decision, entry count and result register.
module lkv_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  lkv_pkg::req_t                       req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output lkv_pkg::rsp_t                       rsp,
    input  logic [lkv_pkg::CAP_W-1:0]           capacity,
    input  logic [lkv_pkg::ENTRIES-1:0]         match_vec,
    input  logic [lkv_pkg::VALUE_BITS-1:0]      hit_value,
    input  logic [lkv_pkg::KEY_BITS-1:0]        tail_key,
    output lkv_pkg::cell_ctl_t                  cell_ctl [lkv_pkg::ENTRIES],
    output lkv_pkg::entry_t                     new_entry,
    output logic [lkv_pkg::KEY_BITS-1:0]        look_key
);

    lkv_pkg::state_t              state_reg, state_next;
    lkv_pkg::req_t                req_reg;
    logic [lkv_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    lkv_pkg::rsp_t                rsp_reg;

    logic                         can_go;
    logic                         commit;
    logic                         hit;
    logic [lkv_pkg::IDX_W-1:0]    hit_pos;
    logic [lkv_pkg::CMP_W-1:0]    cap_ext;
    logic [lkv_pkg::CMP_W-1:0]    eff_cap;
    logic                         evict;
    logic                         change;
    logic [lkv_pkg::IDX_W-1:0]    shift_top;
    lkv_pkg::rsp_t                rsp_new;

    assign can_go = !rsp_valid_reg || rsp_ready;
    assign hit    = |match_vec;

    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                hit_pos = hit_pos | lkv_pkg::IDX_W'(i);
            end
        end
    end

    // capacity zero acts as one, anything above the slot count as the slot count
    always_comb
    begin
        cap_ext = lkv_pkg::CMP_W'(capacity);
        eff_cap = cap_ext;
        if (cap_ext == '0)
        begin
            eff_cap = lkv_pkg::CMP_W'(1);
        end
        else if (cap_ext > lkv_pkg::CMP_W'(lkv_pkg::ENTRIES))
        begin
            eff_cap = lkv_pkg::CMP_W'(lkv_pkg::ENTRIES);
        end
    end

    assign evict  = (req_reg.mode == lkv_pkg::MODE_PUT) && !hit
                    && (lkv_pkg::CMP_W'(count_reg) >= eff_cap);
    assign change = hit || (req_reg.mode == lkv_pkg::MODE_PUT);

    always_comb
    begin
        if (hit)
        begin
            shift_top = hit_pos;
        end
        else if (evict)
        begin
            shift_top = lkv_pkg::IDX_W'(count_reg - lkv_pkg::CNT_W'(1));
        end
        else
        begin
            shift_top = lkv_pkg::IDX_W'(count_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lkv_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lkv_pkg::ST_LOOK;
                end
            end
            lkv_pkg::ST_LOOK:
            begin
                state_next = lkv_pkg::ST_UPDATE;
            end
            lkv_pkg::ST_UPDATE:
            begin
                if (can_go)
                begin
                    state_next = lkv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            lkv_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            lkv_pkg::ST_UPDATE:
            begin
                commit = can_go;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            cell_ctl[i].look  = (state_reg == lkv_pkg::ST_LOOK);
            cell_ctl[i].shift = commit && change
                                && ((i == 0) || (lkv_pkg::IDX_W'(i) <= shift_top));
        end
    end

    assign new_entry.valid = 1'b1;
    assign new_entry.key   = req_reg.key;
    assign new_entry.value = (req_reg.mode == lkv_pkg::MODE_PUT) ? req_reg.value : hit_value;
    assign look_key        = req_reg.key;

    always_comb
    begin
        rsp_new.hit         = hit;
        rsp_new.read_value  = (hit && (req_reg.mode == lkv_pkg::MODE_GET)) ? hit_value : '0;
        rsp_new.evicted     = evict;
        rsp_new.evicted_key = evict ? tail_key : '0;
    end

    always_comb
    begin
        count_next = count_reg;
        if (commit && (req_reg.mode == lkv_pkg::MODE_PUT) && !hit && !evict)
        begin
            count_next = count_reg + lkv_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkv_pkg::ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (commit)
        begin
            rsp_reg <= rsp_new;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lkv_pkg::CNT_W'(lkv_pkg::ENTRIES))
        else $error("entry count above slot count");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lkv_pkg::ST_UPDATE) |-> $onehot0(match_vec))
        else $error("key matched in more than one slot");

    a_rsp_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == lkv_pkg::ST_UPDATE)
        else $error("result raised outside update");

    a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.evicted) |-> !rsp_reg.hit)
        else $error("eviction reported on a hit");
`endif

endmodule

// ===== src/lru_key_value_cache_unit.sv =====
// Top level of the fully associative LRU key-value cache built as a chain of recency cells.
//
// Usage:
//   Requests enter on req (mode, key, value) with req_valid / req_ready; a get
//   has mode 0, a put mode 1. One result per request leaves on rsp (hit,
//   read_value, evicted, evicted_key) with rsp_valid / rsp_ready.
//   capacity_we / capacity_wdata write the capacity register (reset 16);
//   write it only while no request is in flight.
// Sequence:
//   Each request passes through capture, key match in every cell, then
//   the update that shifts the cell chain and loads the result register. A
//   new request is taken only once the update of the last one is done; the
//   sequencer handles one request at a time.
// Organization:
//   Cell 0 holds the most recent entry, cell count-1 the least recent. A hit
//   moves its entry to cell 0 while the cells in front advance one place; an
//   insert advances all valid cells and drops the last one when it evicts.
// Reset and stall:
//   Reset empties every cell and drops any pending result. When rsp_ready is
//   low the result register holds its request; the next request is still
//   taken and runs up to the update step, where it waits for the register.
module lru_key_value_cache_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  lkv_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output lkv_pkg::rsp_t                 rsp,
    input  logic                          capacity_we,
    input  logic [lkv_pkg::CAP_W-1:0]     capacity_wdata
);

    logic [lkv_pkg::CAP_W-1:0]       capacity_reg;

    lkv_pkg::cell_ctl_t              cell_ctl   [lkv_pkg::ENTRIES];
    lkv_pkg::entry_t                 cell_entry [lkv_pkg::ENTRIES];
    lkv_pkg::entry_t                 cell_in    [lkv_pkg::ENTRIES];
    logic [lkv_pkg::ENTRIES-1:0]     next_valid;
    logic [lkv_pkg::ENTRIES-1:0]     match_vec;
    logic [lkv_pkg::VALUE_BITS-1:0]  cell_hit_value [lkv_pkg::ENTRIES];
    logic [lkv_pkg::KEY_BITS-1:0]    cell_tail_key  [lkv_pkg::ENTRIES];
    logic [lkv_pkg::VALUE_BITS-1:0]  hit_value;
    logic [lkv_pkg::KEY_BITS-1:0]    tail_key;
    lkv_pkg::entry_t                 new_entry;
    logic [lkv_pkg::KEY_BITS-1:0]    look_key;

    // capacity register: write on enable, no handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkv_pkg::CAP_W'(lkv_pkg::CAP_RESET);
        end
        else if (capacity_we)
        begin
            capacity_reg <= capacity_wdata;
        end
    end

    lkv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .capacity  (capacity_reg),
        .match_vec (match_vec),
        .hit_value (hit_value),
        .tail_key  (tail_key),
        .cell_ctl  (cell_ctl),
        .new_entry (new_entry),
        .look_key  (look_key)
    );

    // chain wiring: cell 0 loads the touched or new entry, the rest take their neighbor
    always_comb
    begin
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            if (i == 0)
            begin
                cell_in[i] = new_entry;
            end
            else
            begin
                cell_in[i] = cell_entry[(i > 0) ? i - 1 : 0];
            end
            if (i == lkv_pkg::ENTRIES - 1)
            begin
                next_valid[i] = 1'b0;
            end
            else
            begin
                next_valid[i] = cell_entry[(i < lkv_pkg::ENTRIES - 1) ? i + 1 : i].valid;
            end
        end
    end

    for (genvar g = 0; g < lkv_pkg::ENTRIES; g++)
    begin : g_cell
        lkv_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl[g]),
            .look_key   (look_key),
            .neighbor   (cell_in[g]),
            .next_valid (next_valid[g]),
            .entry      (cell_entry[g]),
            .match      (match_vec[g]),
            .hit_value  (cell_hit_value[g]),
            .tail_key   (cell_tail_key[g])
        );
    end

    // at most one cell drives a nonzero hit value or tail key, so OR them together
    always_comb
    begin
        hit_value = '0;
        tail_key  = '0;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            hit_value = hit_value | cell_hit_value[i];
            tail_key  = tail_key | cell_tail_key[i];
        end
    end

endmodule
